// File: src/fpmt_pkg.sv
// ----------------------------------------------------------------------------
// fpmt_pkg: shared types and constants
// Sizes, the empty value, command and state codes for the prefix-minimum tree.
// ----------------------------------------------------------------------------
package fpmt_pkg;

  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned POS_W  = 11;
  localparam int unsigned VAL_W  = 64;

  localparam logic signed [VAL_W-1:0] EMPTY_VALUE = 64'sd1000000000000000000;
  localparam logic [POS_W-1:0]        SIZE_RESET  = POS_W'(DEPTH);
  localparam logic [POS_W-1:0]        DEPTH_POS   = POS_W'(DEPTH);

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_e;

endpackage

// File: src/fpmt_ram.sv
// ----------------------------------------------------------------------------
// fpmt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fpmt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/fenwick_prefix_min_tree_top.sv
// Sequence: an accepted item walks its chain with one store read per chain node
// (at most 11) through the single read port, then a drain step and a result step;
// an ignored update or a query of position 0 goes straight to the result step.
// A new request is taken only after the previous result has been loaded for output.
// Reset: after rst_ni rises, a clearing pass writes the empty value to all 1024
// entries, one per cycle, before the first request is taken; tree_size resets to 1024.
// ----------------------------------------------------------------------------
// fenwick_prefix_min_tree_top: prefix-minimum binary indexed tree
// Updates lower the minimum along the upward lowbit chain, queries fold the
// minimum along the downward chain, with a read-modify-write on one RAM.
// ----------------------------------------------------------------------------
module fenwick_prefix_min_tree_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [fpmt_pkg::POS_W-1:0]            cfg_tree_size_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  cmd_i,
  input  logic [fpmt_pkg::POS_W-1:0]            position_i,
  input  logic signed [fpmt_pkg::VAL_W-1:0]     value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [fpmt_pkg::VAL_W-1:0]     min_value_o,
  output logic                                  is_empty_o,
  output logic                                  ignored_o
);

  fpmt_pkg::state_e state_q, state_d;

  logic [fpmt_pkg::ADDR_W-1:0]        clr_q;
  logic [fpmt_pkg::POS_W-1:0]         tsize_q;
  logic [fpmt_pkg::POS_W-1:0]         size_n;
  logic                               cmd_q;
  logic signed [fpmt_pkg::VAL_W-1:0]  val_q;
  logic [fpmt_pkg::POS_W-1:0]         p_q;
  logic signed [fpmt_pkg::VAL_W-1:0]  acc_q;
  logic                               ign_q;
  logic                               rd_vld_q;
  logic [fpmt_pkg::ADDR_W-1:0]        rd_addr_q;

  logic                               out_vld_q;
  logic signed [fpmt_pkg::VAL_W-1:0]  out_min_q;
  logic                               out_empty_q;
  logic                               out_ign_q;

  logic                               in_acc;
  logic                               out_free;
  logic                               start_trivial;
  logic [fpmt_pkg::POS_W-1:0]         start_pos;
  logic                               start_ign;
  logic [fpmt_pkg::POS_W-1:0]         lowbit;
  logic [fpmt_pkg::POS_W:0]           p_up;
  logic [fpmt_pkg::POS_W-1:0]         p_dn;
  logic                               walk_more;
  logic [fpmt_pkg::ADDR_W-1:0]        rd_addr;
  logic [fpmt_pkg::POS_W-1:0]         p_m1;

  logic                               mem_we;
  logic [fpmt_pkg::ADDR_W-1:0]        mem_waddr;
  logic [fpmt_pkg::VAL_W-1:0]         mem_wdata;
  logic [fpmt_pkg::VAL_W-1:0]         mem_rdata;
  logic signed [fpmt_pkg::VAL_W-1:0]  rd_val;
  logic                               load_out;

  fpmt_ram #(
    .WIDTH (fpmt_pkg::VAL_W),
    .DEPTH (fpmt_pkg::DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (rd_addr),
    .rdata_o (mem_rdata)
  );

  assign rd_val = $signed(mem_rdata);

  // size in use saturates at the store depth
  assign size_n = (tsize_q > fpmt_pkg::DEPTH_POS) ? fpmt_pkg::DEPTH_POS : tsize_q;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_vld_q || !out_stall_i;

  always_comb begin
    start_ign = 1'b0;
    if (cmd_i == fpmt_pkg::CMD_UPDATE) begin
      start_ign = (position_i == '0) || (position_i > size_n);
      start_pos = position_i;
    end else begin
      start_pos = (position_i > size_n) ? size_n : position_i;
    end
    start_trivial = start_ign || (start_pos == '0);
  end

  assign lowbit    = p_q & (~p_q + 1'b1);
  assign p_up      = {1'b0, p_q} + {1'b0, lowbit};
  assign p_dn      = p_q - lowbit;
  assign walk_more = (cmd_q == fpmt_pkg::CMD_UPDATE) ? (p_up <= {1'b0, size_n})
                                                     : (p_dn != '0);
  assign p_m1      = p_q - 1'b1;
  assign rd_addr   = p_m1[fpmt_pkg::ADDR_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fpmt_pkg::ST_CLEAR: begin
        if (clr_q == fpmt_pkg::ADDR_W'(fpmt_pkg::DEPTH - 1)) begin
          state_d = fpmt_pkg::ST_IDLE;
        end
      end
      fpmt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = start_trivial ? fpmt_pkg::ST_FINISH : fpmt_pkg::ST_WALK;
        end
      end
      fpmt_pkg::ST_WALK: begin
        if (!walk_more) begin
          state_d = fpmt_pkg::ST_DRAIN;
        end
      end
      fpmt_pkg::ST_DRAIN: state_d = fpmt_pkg::ST_FINISH;
      fpmt_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = fpmt_pkg::ST_IDLE;
        end
      end
      default: state_d = fpmt_pkg::ST_CLEAR;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = rd_addr_q;
    mem_wdata  = val_q;
    case (state_q)
      fpmt_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = fpmt_pkg::EMPTY_VALUE;
      end
      fpmt_pkg::ST_IDLE:   in_stall_o = 1'b0;
      fpmt_pkg::ST_FINISH: load_out = out_free;
      default: ;
    endcase
    // lower the stored minimum as the read data returns
    if (rd_vld_q && (cmd_q == fpmt_pkg::CMD_UPDATE) && (val_q < rd_val)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fpmt_pkg::ST_CLEAR;
      clr_q     <= '0;
      tsize_q   <= fpmt_pkg::SIZE_RESET;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == fpmt_pkg::ST_WALK);
      if (state_q == fpmt_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cfg_valid_i) begin
        tsize_q <= cfg_tree_size_i;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= cmd_i;
      val_q <= value_i;
      p_q   <= start_pos;
      ign_q <= start_ign;
      acc_q <= fpmt_pkg::EMPTY_VALUE;
    end else begin
      if (state_q == fpmt_pkg::ST_WALK) begin
        p_q <= (cmd_q == fpmt_pkg::CMD_UPDATE) ? p_up[fpmt_pkg::POS_W-1:0] : p_dn;
      end
      // fold the minimum along the query chain
      if (rd_vld_q && (cmd_q == fpmt_pkg::CMD_QUERY) && (rd_val < acc_q)) begin
        acc_q <= rd_val;
      end
    end
    rd_addr_q <= rd_addr;
    if (load_out) begin
      if (cmd_q == fpmt_pkg::CMD_QUERY) begin
        out_min_q   <= acc_q;
        out_empty_q <= (acc_q == fpmt_pkg::EMPTY_VALUE);
        out_ign_q   <= 1'b0;
      end else begin
        out_min_q   <= '0;
        out_empty_q <= 1'b0;
        out_ign_q   <= ign_q;
      end
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign min_value_o = out_min_q;
  assign is_empty_o  = out_empty_q;
  assign ignored_o   = out_ign_q;

`ifndef NO_ASSERTIONS
  a_rd_follows_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q == fpmt_pkg::ST_WALK))
    else $error("read data valid without a walk cycle before it");

  a_no_write_on_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && (state_q != fpmt_pkg::ST_CLEAR)) |-> (cmd_q == fpmt_pkg::CMD_UPDATE))
    else $error("store written during a query");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_empty_o) |-> (min_value_o == fpmt_pkg::EMPTY_VALUE))
    else $error("empty flag set with a stored minimum");

  a_ignored_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ignored_o) |-> (!is_empty_o && (min_value_o == '0)))
    else $error("ignored update carries query fields");
`endif

endmodule

// File: tb/fenwick_prefix_min_tree_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fenwick_prefix_min_tree_checker: result predictor and comparator
// Watches the configuration, request and result channels of the prefix-minimum
// tree. Keeps its own copy of the node store and the tree size, predicts one
// result per accepted request and compares every accepted result against the
// oldest prediction.
// ----------------------------------------------------------------------------
module fenwick_prefix_min_tree_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [fpmt_pkg::POS_W-1:0]        cfg_tree_size_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic                              cmd_i,
  input  logic [fpmt_pkg::POS_W-1:0]        position_i,
  input  logic signed [fpmt_pkg::VAL_W-1:0] value_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [fpmt_pkg::VAL_W-1:0] min_value_i,
  input  logic                              is_empty_i,
  input  logic                              ignored_i,
  output int                                pending_o,
  output int                                fail_count_o
);

  typedef struct packed {
    logic signed [fpmt_pkg::VAL_W-1:0] min_value;
    logic                              is_empty;
    logic                              ignored;
  } tree_result_t;

  logic signed [fpmt_pkg::VAL_W-1:0] node_min [1:fpmt_pkg::DEPTH];
  logic [fpmt_pkg::POS_W-1:0]        size_reg;
  tree_result_t                      awaited_results [$];
  tree_result_t                      want;
  tree_result_t                      got;
  tree_result_t                      predicted;
  int                                mismatches;

  // Lower the upward chain for an update, fold the downward chain for a query.
  function automatic tree_result_t walk_tree(input fpmt_pkg::cmd_e cmd,
                                             input logic [fpmt_pkg::POS_W-1:0] pos,
                                             input logic signed [fpmt_pkg::VAL_W-1:0] val);
    int unsigned                       n;
    int unsigned                       p;
    logic signed [fpmt_pkg::VAL_W-1:0] best;
    tree_result_t                      r;
    n = (size_reg > fpmt_pkg::DEPTH) ? fpmt_pkg::DEPTH : 32'(size_reg);
    p = 32'(pos);
    r = '0;
    if (cmd == fpmt_pkg::CMD_UPDATE) begin
      if (p < 1 || p > n) begin
        r.ignored = 1'b1;
      end else begin
        while (p <= n) begin
          if (val < node_min[p]) node_min[p] = val;
          p += p & (~p + 1);
        end
      end
    end else begin
      best = fpmt_pkg::EMPTY_VALUE;
      if (p > n) p = n;
      while (p != 0) begin
        if (node_min[p] < best) best = node_min[p];
        p -= p & (~p + 1);
      end
      r.min_value = best;
      r.is_empty  = (best == fpmt_pkg::EMPTY_VALUE);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input tree_result_t exp_r,
                                 input tree_result_t act_r);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected min_value=%0d is_empty=%0b ignored=%0b", $realtime, what,
               exp_r.min_value, exp_r.is_empty, exp_r.ignored);
      $display("[%0t] %s:   actual min_value=%0d is_empty=%0b ignored=%0b", $realtime, what,
               act_r.min_value, act_r.is_empty, act_r.ignored);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i <= fpmt_pkg::DEPTH; i++) node_min[i] = fpmt_pkg::EMPTY_VALUE;
      size_reg = fpmt_pkg::SIZE_RESET;
      awaited_results.delete();
      mismatches = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) size_reg = cfg_tree_size_i;
      if (out_valid_i && !out_stall_i) begin
        got.min_value = min_value_i;
        got.is_empty  = is_empty_i;
        got.ignored   = ignored_i;
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result", '0, got);
        end else begin
          want = awaited_results.pop_front();
          if (got.min_value !== want.min_value || got.is_empty !== want.is_empty ||
              got.ignored !== want.ignored) begin
            report_mismatch("result mismatch", want, got);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predicted = walk_tree(fpmt_pkg::cmd_e'(cmd_i), position_i, value_i);
        awaited_results = {awaited_results, predicted};
      end
      pending_o    <= awaited_results.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// File: tb/tb_fenwick_prefix_min_tree_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fenwick_prefix_min_tree_top: testbench for the prefix-minimum tree
// Drives a directed sweep of range edges and empty cases, then random update
// and query traffic over a series of tree sizes with varying backpressure.
// Checking is done by the checker instance; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_fenwick_prefix_min_tree_top;

  localparam int TIMEOUT_CYCLES = 500000;
  localparam int HOLD_CYCLES    = 400;

  logic                              clk_i           = 1'b0;
  logic                              rst_ni          = 1'b0;
  logic                              cfg_valid_i     = 1'b0;
  logic                              cfg_ready_o;
  logic [fpmt_pkg::POS_W-1:0]        cfg_tree_size_i = '0;
  logic                              in_valid_i      = 1'b0;
  logic                              in_stall_o;
  logic                              cmd_i           = 1'b0;
  logic [fpmt_pkg::POS_W-1:0]        position_i      = '0;
  logic signed [fpmt_pkg::VAL_W-1:0] value_i         = '0;
  logic                              out_valid_o;
  logic                              out_stall_i     = 1'b0;
  logic signed [fpmt_pkg::VAL_W-1:0] min_value_o;
  logic                              is_empty_o;
  logic                              ignored_o;

  int                                pending;
  int                                fail_count;
  int                                idle_pct    = 0;
  int                                stall_pct   = 0;
  int                                holds_asked = 0;
  int                                holds_done  = 0;
  int                                hold_left   = 0;
  int                                cycles      = 0;
  logic [fpmt_pkg::POS_W-1:0]        size_now    = fpmt_pkg::SIZE_RESET;
  logic signed [fpmt_pkg::VAL_W-1:0] level       = 64'sd1000000000000;

  fenwick_prefix_min_tree_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_tree_size_i (cfg_tree_size_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .min_value_o     (min_value_o),
    .is_empty_o      (is_empty_o),
    .ignored_o       (ignored_o)
  );

  fenwick_prefix_min_tree_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_tree_size_i (cfg_tree_size_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .cmd_i           (cmd_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .min_value_i     (min_value_o),
    .is_empty_i      (is_empty_o),
    .ignored_i       (ignored_o),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when one is asked for.
  always @(posedge clk_i) begin
    if (holds_done != holds_asked) begin
      holds_done  <= holds_asked;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    while (cycles < TIMEOUT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_request(input fpmt_pkg::cmd_e cmd,
                              input logic [fpmt_pkg::POS_W-1:0] pos,
                              input logic signed [fpmt_pkg::VAL_W-1:0] val);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and hold until every outstanding result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_tree_size(input logic [fpmt_pkg::POS_W-1:0] sz);
    wait_drained();
    cfg_valid_i     <= 1'b1;
    cfg_tree_size_i <= sz;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    size_now = sz;
  endtask

  // Mostly values just under the current level, so newer updates win.
  function automatic logic signed [fpmt_pkg::VAL_W-1:0] pick_value();
    int unsigned                       k;
    logic signed [fpmt_pkg::VAL_W-1:0] v;
    k = $urandom_range(0, 99);
    if (k < 80) begin
      v = level - $signed(64'($urandom_range(0, 24'hFF_FFFF)));
    end else if (k < 93) begin
      v = {$urandom, $urandom};
      v[fpmt_pkg::VAL_W-1] = 1'b0;
    end else begin
      v = fpmt_pkg::EMPTY_VALUE + $signed(64'($urandom_range(0, 2))) - 64'sd1;
    end
    return v;
  endfunction

  task automatic run_batch(input int count, input int batch);
    int unsigned                n;
    int unsigned                k;
    logic [fpmt_pkg::POS_W-1:0] pos;
    n = (size_now > fpmt_pkg::DEPTH) ? fpmt_pkg::DEPTH : 32'(size_now);
    for (int i = 0; i < count; i++) begin
      if (batch == 0 && i == 20) holds_asked <= holds_asked + 1;
      if (batch == 4 && i == 75) wait_drained();
      k = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 55) begin
        if (k < 88 && n > 0) pos = fpmt_pkg::POS_W'($urandom_range(1, n));
        else if (k < 94)     pos = '0;
        else                 pos = fpmt_pkg::POS_W'($urandom_range(n + 1, 2047));
        send_request(fpmt_pkg::CMD_UPDATE, pos, pick_value());
      end else begin
        if (k < 85)      pos = fpmt_pkg::POS_W'($urandom_range(0, n));
        else if (k < 95) pos = fpmt_pkg::POS_W'($urandom_range(n, 2047));
        else             pos = '1;
        send_request(fpmt_pkg::CMD_QUERY, pos, {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_tree_size(11'd16);
    send_request(fpmt_pkg::CMD_QUERY, 11'd0, 64'sd0);
    send_request(fpmt_pkg::CMD_QUERY, 11'd2047, 64'sd0);
    send_request(fpmt_pkg::CMD_UPDATE, 11'd0, 64'sd5);
    send_request(fpmt_pkg::CMD_UPDATE, 11'd17, 64'sd5);
    send_request(fpmt_pkg::CMD_UPDATE, 11'd2047, -64'sd5);
    send_request(fpmt_pkg::CMD_UPDATE, 11'd5, fpmt_pkg::EMPTY_VALUE);
    send_request(fpmt_pkg::CMD_QUERY, 11'd16, 64'sd0);
    send_request(fpmt_pkg::CMD_UPDATE, 11'd16, 64'sh7FFF_FFFF_FFFF_FFFF);
    send_request(fpmt_pkg::CMD_UPDATE, 11'd3, 64'sd1000);
    send_request(fpmt_pkg::CMD_UPDATE, 11'd12, -64'sd77);
    send_request(fpmt_pkg::CMD_QUERY, 11'd2, 64'sd0);
    send_request(fpmt_pkg::CMD_QUERY, 11'd3, 64'sd0);
    send_request(fpmt_pkg::CMD_QUERY, 11'd11, 64'sd0);
    send_request(fpmt_pkg::CMD_QUERY, 11'd12, 64'sd0);
    send_request(fpmt_pkg::CMD_QUERY, 11'd2047, 64'sd0);
    send_request(fpmt_pkg::CMD_UPDATE, 11'd1, fpmt_pkg::EMPTY_VALUE - 64'sd1);
    send_request(fpmt_pkg::CMD_QUERY, 11'd1, 64'sd0);
    // zero size: nothing is in range
    set_tree_size(11'd0);
    send_request(fpmt_pkg::CMD_UPDATE, 11'd1, 64'sd3);
    send_request(fpmt_pkg::CMD_QUERY, 11'd5, 64'sd0);
    // oversize setting saturates at the full depth
    set_tree_size(11'd2047);
    send_request(fpmt_pkg::CMD_UPDATE, 11'd1024, 64'sh8000_0000_0000_0000);
    send_request(fpmt_pkg::CMD_QUERY, 11'd1023, 64'sd0);
    send_request(fpmt_pkg::CMD_QUERY, 11'd2047, 64'sd0);
    send_request(fpmt_pkg::CMD_QUERY, 11'd1024, 64'sd0);
    set_tree_size(11'd1);
    send_request(fpmt_pkg::CMD_UPDATE, 11'd1, 64'sd2);
    send_request(fpmt_pkg::CMD_UPDATE, 11'd2, 64'sd1);
    send_request(fpmt_pkg::CMD_QUERY, 11'd2047, 64'sd0);

    for (int b = 0; b < 10; b++) begin
      case (b)
        0:       set_tree_size(11'd1024);
        1:       set_tree_size(11'd3);
        2:       set_tree_size(11'd64);
        3:       set_tree_size(11'd1000);
        4:       set_tree_size(11'd2047);
        5:       set_tree_size(11'd1);
        6:       set_tree_size(11'd513);
        7:       set_tree_size(11'd0);
        8:       set_tree_size(11'd1024);
        default: set_tree_size(11'd200);
      endcase
      case (b % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 48; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 9;  stall_pct = 9;  end
      endcase
      level = level - 64'sd300000000000;
      run_batch((b == 7) ? 30 : 144, b);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
src/fpmt_pkg.sv
src/fpmt_ram.sv
src/fenwick_prefix_min_tree_top.sv
tb/fenwick_prefix_min_tree_checker.sv
tb/tb_fenwick_prefix_min_tree_top.sv
